/* design/cpf_pkg.sv */
`timescale 1ns / 1ps

package cpf_pkg;

   localparam int TILE_ATOMS = 32;

   localparam int POS_W   = 24;
   localparam int DIFF_W  = POS_W + 2;
   localparam int WIDE_W  = POS_W + 3;
   localparam int SQ_W    = 2 * DIFF_W - 2;
   localparam int ACC_W   = SQ_W + 2;
   localparam int CUT_W   = 48;
   localparam int EXCL_W  = 16;
   localparam int ID_W    = 5;
   localparam int COUNT_W = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [POS_W-1:0]   BOX_RESET     = '1;
   localparam logic [CUT_W-1:0]   CUTOFF_RESET  = '0;
   localparam logic [EXCL_W-1:0]  EXCLUDE_RESET = 16'd43;
   localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_PROBE = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOX_X     = 3'd0,
      CSR_BOX_Y     = 3'd1,
      CSR_BOX_Z     = 3'd2,
      CSR_CUTOFF    = 3'd3,
      CSR_EXCLUDE   = 3'd4,
      CSR_SAME_TILE = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_AXIS,
      S_TEST,
      S_SUMMARY
   } state_type;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [ID_W-1:0]  probe_index;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [POS_W-1:0] pos_z;
   } req_payload_type;

   typedef struct packed {
      logic [ID_W-1:0]    probe_id;
      logic [ID_W-1:0]    neighbor_index;
      logic               hit;
      logic               last;
      logic [COUNT_W-1:0] pair_count;
   } rsp_payload_type;

   typedef struct packed {
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic [POS_W-1:0] z;
   } atom_pos_type;

   typedef struct packed {
      logic fold_en;
      logic square_en;
   } axis_ctrl_type;

endpackage

/* design/cutoff_pair_finder_unit.sv */
`timescale 1ns / 1ps
// Load and clear: handled in the idle state, ready again on the next cycle.
// Probe: accepted, then each stored atom is either skipped or tested (store read, 3 axis
// folds through one shared fold/square unit, compare); the probe closes with an end-of-store
// check and a summary; a stalled result register holds back the pair and summary results.
// One item is worked at a time; the shared axis unit sets the per-atom cost.
// Reset (synchronous): clears control, counts and config registers; data registers and store contents stay undefined.

module cutoff_pair_finder_unit #(
   parameter int TILE_ATOMS = cpf_pkg::TILE_ATOMS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  cpf_pkg::req_payload_type            req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output cpf_pkg::rsp_payload_type            rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [cpf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cpf_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   localparam int IDX_W = (TILE_ATOMS > 1) ? $clog2(TILE_ATOMS) : 1;
   localparam int CNT_W = $clog2(TILE_ATOMS + 1);
   localparam logic [2:0] PH_FOLD_END = 3'd3;
   localparam logic [2:0] PH_ACC_INIT = 3'd2;
   localparam logic [2:0] PH_LAST     = 3'd4;

   logic [cpf_pkg::POS_W-1:0]   box_x_ff, box_y_ff, box_z_ff;
   logic [cpf_pkg::CUT_W-1:0]   cutoff_ff;
   logic [cpf_pkg::EXCL_W-1:0]  exclude_ff;
   logic                        same_tile_ff;

   cpf_pkg::state_type          state_ff, state_in;
   logic [CNT_W-1:0]            j_ff, j_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [cpf_pkg::COUNT_W-1:0] total_ff, total_in;
   logic [2:0]                  ph_ff, ph_in;
   logic [cpf_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic [cpf_pkg::ID_W-1:0]    pid_ff, pid_in;
   cpf_pkg::atom_pos_type       probe_ff, probe_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   cpf_pkg::rsp_payload_type    rsp_ff, rsp_in;

   cpf_pkg::atom_pos_type       mem [TILE_ATOMS];
   cpf_pkg::atom_pos_type       rd_ff;
   logic                        mem_we;
   cpf_pkg::atom_pos_type       wr_pos;

   logic                        req_xfer;
   logic                        out_free;
   logic                        in_range;
   logic                        hit;
   logic [CNT_W+cpf_pkg::ID_W-1:0] j_ext;
   logic [cpf_pkg::COUNT_W-1:0] total_bump;

   cpf_pkg::axis_ctrl_type      axis_ctrl;
   logic [cpf_pkg::POS_W-1:0]   ax_probe, ax_nbr, ax_box;
   logic [cpf_pkg::SQ_W-1:0]    ax_square;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff     <= cpf_pkg::BOX_RESET;
         box_y_ff     <= cpf_pkg::BOX_RESET;
         box_z_ff     <= cpf_pkg::BOX_RESET;
         cutoff_ff    <= cpf_pkg::CUTOFF_RESET;
         exclude_ff   <= cpf_pkg::EXCLUDE_RESET;
         same_tile_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            cpf_pkg::CSR_BOX_X:     box_x_ff     <= csr_wr_data[cpf_pkg::POS_W-1:0];
            cpf_pkg::CSR_BOX_Y:     box_y_ff     <= csr_wr_data[cpf_pkg::POS_W-1:0];
            cpf_pkg::CSR_BOX_Z:     box_z_ff     <= csr_wr_data[cpf_pkg::POS_W-1:0];
            cpf_pkg::CSR_CUTOFF:    cutoff_ff    <= csr_wr_data[cpf_pkg::CUT_W-1:0];
            cpf_pkg::CSR_EXCLUDE:   exclude_ff   <= csr_wr_data[cpf_pkg::EXCL_W-1:0];
            cpf_pkg::CSR_SAME_TILE: same_tile_ff <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != cpf_pkg::S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign j_ext      = {{cpf_pkg::ID_W{1'b0}}, j_ff};
   assign in_range   = j_ff < count_ff;
   assign hit        = (acc_ff < cpf_pkg::ACC_W'(cutoff_ff)) &&
                       (acc_ff > cpf_pkg::ACC_W'(exclude_ff));
   assign total_bump = (total_ff == cpf_pkg::COUNT_MAX) ? total_ff : total_ff + 1'b1;

   always_comb begin
      wr_pos.x = req_payload.pos_x;
      wr_pos.y = req_payload.pos_y;
      wr_pos.z = req_payload.pos_z;
      mem_we   = req_xfer && (req_payload.cmd == cpf_pkg::CMD_LOAD) &&
                 (count_ff < CNT_W'(TILE_ATOMS));
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[IDX_W-1:0]] <= wr_pos;
      end
      rd_ff <= mem[j_ff[IDX_W-1:0]];
   end

   always_comb begin
      case (ph_ff)
         3'd0: begin
            ax_probe = probe_ff.x;
            ax_nbr   = rd_ff.x;
            ax_box   = box_x_ff;
         end
         3'd1: begin
            ax_probe = probe_ff.y;
            ax_nbr   = rd_ff.y;
            ax_box   = box_y_ff;
         end
         default: begin
            ax_probe = probe_ff.z;
            ax_nbr   = rd_ff.z;
            ax_box   = box_z_ff;
         end
      endcase
      axis_ctrl.fold_en   = (state_ff == cpf_pkg::S_AXIS) && (ph_ff < PH_FOLD_END);
      axis_ctrl.square_en = (state_ff == cpf_pkg::S_AXIS) && (ph_ff != 3'd0) &&
                            (ph_ff <= PH_FOLD_END);
   end

   cpf_axis_unit u_axis (
      .clock     (clock),
      .ctrl      (axis_ctrl),
      .probe_pos (ax_probe),
      .nbr_pos   (ax_nbr),
      .box_len   (ax_box),
      .square    (ax_square)
   );

   always_comb begin
      state_in     = state_ff;
      j_in         = j_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      ph_in        = ph_ff;
      acc_in       = acc_ff;
      pid_in       = pid_ff;
      probe_in     = probe_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         cpf_pkg::S_IDLE: begin
            if (req_xfer) begin
               case (req_payload.cmd)
                  cpf_pkg::CMD_LOAD: begin
                     if (mem_we) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  cpf_pkg::CMD_CLEAR: begin
                     count_in = '0;
                     total_in = '0;
                  end
                  cpf_pkg::CMD_PROBE: begin
                     pid_in   = req_payload.probe_index;
                     probe_in = wr_pos;
                     j_in     = '0;
                     state_in = cpf_pkg::S_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         cpf_pkg::S_SCAN: begin
            if (!in_range) begin
               state_in = cpf_pkg::S_SUMMARY;
            end else if (same_tile_ff &&
                         (j_ext <= {{CNT_W{1'b0}}, pid_ff})) begin
               j_in = j_ff + 1'b1;
            end else begin
               ph_in    = '0;
               state_in = cpf_pkg::S_AXIS;
            end
         end
         cpf_pkg::S_AXIS: begin
            if (ph_ff == PH_ACC_INIT) begin
               acc_in = cpf_pkg::ACC_W'(ax_square);
            end else if (ph_ff > PH_ACC_INIT) begin
               acc_in = acc_ff + cpf_pkg::ACC_W'(ax_square);
            end
            ph_in = ph_ff + 1'b1;
            if (ph_ff == PH_LAST) begin
               state_in = cpf_pkg::S_TEST;
            end
         end
         cpf_pkg::S_TEST: begin
            if (!hit) begin
               j_in     = j_ff + 1'b1;
               state_in = cpf_pkg::S_SCAN;
            end else if (out_free) begin
               total_in              = total_bump;
               rsp_valid_in          = 1'b1;
               rsp_in.probe_id       = pid_ff;
               rsp_in.neighbor_index = j_ext[cpf_pkg::ID_W-1:0];
               rsp_in.hit            = 1'b1;
               rsp_in.last           = 1'b0;
               rsp_in.pair_count     = total_bump;
               j_in                  = j_ff + 1'b1;
               state_in              = cpf_pkg::S_SCAN;
            end
         end
         cpf_pkg::S_SUMMARY: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.probe_id       = pid_ff;
               rsp_in.neighbor_index = '0;
               rsp_in.hit            = 1'b0;
               rsp_in.last           = 1'b1;
               rsp_in.pair_count     = total_ff;
               state_in              = cpf_pkg::S_IDLE;
            end
         end
         default: state_in = cpf_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpf_pkg::S_IDLE;
         j_ff         <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         ph_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         j_ff         <= j_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         ph_ff        <= ph_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      pid_ff   <= pid_in;
      probe_ff <= probe_in;
      rsp_ff   <= rsp_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TILE_ATOMS))
      else $error("store fill count above capacity");

   a_axis_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cpf_pkg::S_AXIS) |-> (j_ff < count_ff))
      else $error("axis work on an entry beyond the fill count");

   a_hit_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.hit != rsp_ff.last))
      else $error("result item is neither a pair nor a summary");

   a_hit_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.hit) |-> (rsp_ff.pair_count != '0))
      else $error("pair item with zero pair count");

endmodule

/* design/cpf_axis_unit.sv */
`timescale 1ns / 1ps

module cpf_axis_unit (
   input  logic                           clock,
   input  cpf_pkg::axis_ctrl_type         ctrl,
   input  logic [cpf_pkg::POS_W-1:0]      probe_pos,
   input  logic [cpf_pkg::POS_W-1:0]      nbr_pos,
   input  logic [cpf_pkg::POS_W-1:0]      box_len,
   output logic [cpf_pkg::SQ_W-1:0]       square
);

   logic signed [cpf_pkg::WIDE_W-1:0]   diff;
   logic signed [cpf_pkg::WIDE_W-1:0]   diff2;
   logic signed [cpf_pkg::WIDE_W-1:0]   box_s;
   logic signed [cpf_pkg::WIDE_W-1:0]   folded;
   logic signed [cpf_pkg::DIFF_W-1:0]   d_ff;
   logic signed [cpf_pkg::DIFF_W-1:0]   d_in;
   logic signed [2*cpf_pkg::DIFF_W-1:0] prod;
   logic [cpf_pkg::SQ_W-1:0]            sq_ff;
   logic [cpf_pkg::SQ_W-1:0]            sq_in;

   always_comb begin
      diff  = $signed({3'b000, probe_pos}) - $signed({3'b000, nbr_pos});
      box_s = $signed({3'b000, box_len});
      diff2 = diff <<< 1;
      if (diff2 >= box_s) begin
         folded = diff - box_s;
      end else if (diff2 <= -box_s) begin
         folded = diff + box_s;
      end else begin
         folded = diff;
      end
      d_in  = folded[cpf_pkg::DIFF_W-1:0];
      prod  = d_ff * d_ff;
      sq_in = prod[cpf_pkg::SQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.fold_en) begin
         d_ff <= d_in;
      end
      if (ctrl.square_en) begin
         sq_ff <= sq_in;
      end
   end

   assign square = sq_ff;

endmodule

/* test/cutoff_pair_finder_unit_tb.sv */
`timescale 1ns / 1ps

module cutoff_pair_finder_unit_tb;
   import cpf_pkg::*;

   localparam logic [1:0]       CMD_SPARE = 2'd3;
   localparam logic [POS_W-1:0] BOX_FULL  = '1;
   localparam logic [POS_W-1:0] BOX_UNIT  = 24'd1;
   localparam logic [CUT_W-1:0] CUT_ALL   = '1;
   localparam int               SETTLE_CYCLES = 20;
   localparam int               HOLD_CYCLES   = 400;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   req_payload_type pending_cmds [$];
   rsp_payload_type expected_hits [$];
   int              items_queued = 0;
   int              items_taken = 0;
   int              mismatches = 0;
   logic            req_fire = 1'b0;
   logic            rsp_fire = 1'b0;
   int              req_gap = 0;
   int              rsp_wait = 0;
   logic            quiet = 1'b0;
   logic            hold_armed = 1'b0;
   logic            long_hold = 1'b0;

   logic [POS_W-1:0]   box_len [3];
   logic [CUT_W-1:0]   cutoff_sq = CUTOFF_RESET;
   logic [EXCL_W-1:0]  exclude_sq = EXCLUDE_RESET;
   logic               same_tile_on = 1'b0;
   atom_pos_type       stored_atoms [TILE_ATOMS];
   int                 stored_count = 0;
   logic [COUNT_W-1:0] pair_total = '0;

   cutoff_pair_finder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int draw_wait();
      if (quiet || $urandom_range(0, 2) == 0) begin
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   function automatic longint unsigned fold_sq(input logic [POS_W-1:0] p, n, box);
      longint d;
      longint span;
      d = longint'(p) - longint'(n);
      span = longint'(box);
      if (2 * d >= span) begin
         d -= span;
      end else if (2 * d <= -span) begin
         d += span;
      end
      if (d < 0) begin
         d = -d;
      end
      return d * d;
   endfunction

   task automatic find_pairs(input req_payload_type item);
      rsp_payload_type r;
      longint unsigned dist_sq;
      int j;
      case (item.cmd)
         CMD_LOAD: begin
            if (stored_count < TILE_ATOMS) begin
               stored_atoms[stored_count] = '{x: item.pos_x, y: item.pos_y, z: item.pos_z};
               stored_count++;
            end
         end
         CMD_CLEAR: begin
            stored_count = 0;
            pair_total = '0;
         end
         CMD_PROBE: begin
            for (j = 0; j < stored_count; j++) begin
               if (same_tile_on && j <= item.probe_index) continue;
               dist_sq = fold_sq(item.pos_x, stored_atoms[j].x, box_len[0])
                       + fold_sq(item.pos_y, stored_atoms[j].y, box_len[1])
                       + fold_sq(item.pos_z, stored_atoms[j].z, box_len[2]);
               if (dist_sq < cutoff_sq && dist_sq > exclude_sq) begin
                  if (pair_total != COUNT_MAX) pair_total++;
                  r = '{probe_id: item.probe_index, neighbor_index: ID_W'(j), hit: 1'b1,
                        last: 1'b0, pair_count: pair_total};
                  expected_hits.push_back(r);
               end
            end
            r = '{probe_id: item.probe_index, neighbor_index: '0, hit: 1'b0, last: 1'b1,
                  pair_count: pair_total};
            expected_hits.push_back(r);
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatches++;
   endtask

   // accept, predict and check at the rising edge
   always @(posedge clock) begin
      rsp_payload_type want;
      req_fire <= !reset && req_valid && !req_stall;
      rsp_fire <= !reset && rsp_valid && !rsp_stall;
      if (!reset && req_valid && !req_stall) begin
         find_pairs(req_payload);
         items_taken++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_hits.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer for probe %0d, neighbor %0d",
                                      rsp_payload.probe_id, rsp_payload.neighbor_index));
         end else begin
            want = expected_hits.pop_front();
            if (rsp_payload.probe_id !== want.probe_id)
               report_mismatch($sformatf("probe_id got %0d, expected %0d",
                                         rsp_payload.probe_id, want.probe_id));
            if (rsp_payload.neighbor_index !== want.neighbor_index)
               report_mismatch($sformatf("neighbor_index got %0d, expected %0d (probe %0d)",
                                         rsp_payload.neighbor_index, want.neighbor_index,
                                         want.probe_id));
            if (rsp_payload.hit !== want.hit)
               report_mismatch($sformatf("hit got %0d, expected %0d (probe %0d)",
                                         rsp_payload.hit, want.hit, want.probe_id));
            if (rsp_payload.last !== want.last)
               report_mismatch($sformatf("last got %0d, expected %0d (probe %0d)",
                                         rsp_payload.last, want.last, want.probe_id));
            if (rsp_payload.pair_count !== want.pair_count)
               report_mismatch($sformatf("pair_count got %0d, expected %0d (probe %0d)",
                                         rsp_payload.pair_count, want.pair_count,
                                         want.probe_id));
         end
      end
   end

   // hold a stalled transfer, otherwise advance after the drawn gap
   always @(negedge clock) begin
      if (!req_valid || req_fire) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_cmds.size() != 0) begin
            req_payload <= pending_cmds.pop_front();
            req_valid <= 1'b1;
            req_gap = draw_wait();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_fire) begin
         rsp_wait = draw_wait();
      end else if (rsp_wait > 0) begin
         rsp_wait--;
      end
      rsp_stall <= long_hold || rsp_wait != 0;
   end

   initial begin
      wait (hold_armed);
      @(negedge clock);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      long_hold <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic atom_pos_type pos(input logic [POS_W-1:0] x, y, z);
      return '{x: x, y: y, z: z};
   endfunction

   function automatic atom_pos_type any_pos();
      return pos(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
   endfunction

   function automatic atom_pos_type near(input atom_pos_type c, input int radius);
      atom_pos_type p;
      p.x = c.x + POS_W'($urandom_range(0, 2 * radius) - radius);
      p.y = c.y + POS_W'($urandom_range(0, 2 * radius) - radius);
      p.z = c.z + POS_W'($urandom_range(0, 2 * radius) - radius);
      return p;
   endfunction

   function automatic logic [POS_W-1:0] pick_box();
      case ($urandom_range(0, 3))
         0: return BOX_UNIT;
         1: return BOX_FULL;
         2: return 24'h100000;
         default: return POS_W'($urandom_range(1, 24'hFFFFFF));
      endcase
   endfunction

   task automatic queue_cmd(input logic [1:0] cmd, input logic [ID_W-1:0] idx,
                            input atom_pos_type p);
      req_payload_type item;
      item.cmd = cmd;
      item.probe_index = idx;
      item.pos_x = p.x;
      item.pos_y = p.y;
      item.pos_z = p.z;
      pending_cmds.push_back(item);
      items_queued++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (items_taken != items_queued || expected_hits.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      case (idx)
         CSR_BOX_X:     box_len[0] = value[POS_W-1:0];
         CSR_BOX_Y:     box_len[1] = value[POS_W-1:0];
         CSR_BOX_Z:     box_len[2] = value[POS_W-1:0];
         CSR_CUTOFF:    cutoff_sq = value[CUT_W-1:0];
         CSR_EXCLUDE:   exclude_sq = value[EXCL_W-1:0];
         CSR_SAME_TILE: same_tile_on = value[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [POS_W-1:0] bx, by, bz,
                             input logic [CUT_W-1:0] cut, input logic [EXCL_W-1:0] excl,
                             input logic same);
      wait_idle();
      write_csr(CSR_BOX_X, CSR_DATA_W'(bx));
      write_csr(CSR_BOX_Y, CSR_DATA_W'(by));
      write_csr(CSR_BOX_Z, CSR_DATA_W'(bz));
      write_csr(CSR_CUTOFF, CSR_DATA_W'(cut));
      write_csr(CSR_EXCLUDE, CSR_DATA_W'(excl));
      write_csr(CSR_SAME_TILE, CSR_DATA_W'(same));
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int ph;
      int k;
      int count;
      int radius;
      logic [CUT_W-1:0] cut;
      atom_pos_type center;

      box_len[0] = BOX_RESET;
      box_len[1] = BOX_RESET;
      box_len[2] = BOX_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      queue_cmd(CMD_PROBE, 5'd31, pos(BOX_FULL, BOX_FULL, BOX_FULL));
      queue_cmd(CMD_SPARE, 5'd31, pos(BOX_FULL, BOX_FULL, BOX_FULL));
      queue_cmd(CMD_LOAD, 5'd0, pos(0, 0, 0));
      queue_cmd(CMD_LOAD, 5'd31, pos(BOX_FULL, BOX_FULL, BOX_FULL));
      queue_cmd(CMD_PROBE, 5'd0, pos(0, 0, 0));

      set_config(24'h100000, 24'h100000, 24'h100000, CUT_ALL, '0, 1'b0);
      queue_cmd(CMD_CLEAR, 5'd0, pos(0, 0, 0));
      queue_cmd(CMD_LOAD, 5'd0, pos(0, 0, 0));
      queue_cmd(CMD_LOAD, 5'd0, pos(24'h080000, 24'h0F0000, BOX_FULL));
      queue_cmd(CMD_LOAD, 5'd0, pos(0, 0, 0));
      queue_cmd(CMD_PROBE, 5'd5, pos(0, 0, 0));
      queue_cmd(CMD_PROBE, 5'd1, pos(24'h080000, 0, 0));

      set_config(BOX_FULL, BOX_FULL, BOX_FULL, 48'd65537, 16'hFFFF, 1'b1);
      queue_cmd(CMD_CLEAR, 5'd7, pos(0, 0, 0));
      for (k = 0; k < 3; k++) begin
         queue_cmd(CMD_LOAD, 5'd31, pos(0, 0, 0));
      end
      queue_cmd(CMD_PROBE, 5'd0, pos(24'h0000FF, 0, 0));
      queue_cmd(CMD_PROBE, 5'd0, pos(24'h000100, 0, 0));
      queue_cmd(CMD_PROBE, 5'd1, pos(24'h000100, 0, 1));
      queue_cmd(CMD_PROBE, 5'd31, pos(24'h000100, 0, 0));
      queue_cmd(CMD_PROBE, 5'd0, pos(24'hFFFEFF, 0, 0));

      for (ph = 0; ph < 3; ph++) begin
         radius = 1 << $urandom_range(4, 14);
         case ($urandom_range(0, 5))
            0: cut = '0;
            1: cut = CUT_ALL;
            default: cut = CUT_W'($urandom_range(0, 3 * radius * radius));
         endcase
         if (ph == 0) begin
            set_config(BOX_UNIT, BOX_UNIT, BOX_UNIT, cut, EXCL_W'($urandom),
                       1'($urandom));
         end else begin
            set_config(pick_box(), pick_box(), pick_box(), cut, EXCL_W'($urandom),
                       1'($urandom));
         end
         quiet = (ph == 1);
         center = any_pos();
         queue_cmd(CMD_CLEAR, ID_W'($urandom), any_pos());
         count = $urandom_range(0, 12);
         for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) == 0) begin
               case ($urandom_range(0, 2))
                  0: queue_cmd(CMD_SPARE, ID_W'($urandom), any_pos());
                  1: queue_cmd(CMD_PROBE, ID_W'($urandom), any_pos());
                  default: queue_cmd(CMD_CLEAR, ID_W'($urandom), any_pos());
               endcase
            end
            queue_cmd(CMD_LOAD, ID_W'($urandom), near(center, radius));
         end
         for (k = 0; k < 4; k++) begin
            queue_cmd(CMD_PROBE, ID_W'($urandom), near(center, radius));
         end
      end

      // drive the pair count into saturation while the result side holds off
      set_config(BOX_FULL, BOX_FULL, BOX_FULL, CUT_ALL, '0, 1'b0);
      quiet = 1'b0;
      hold_armed = 1'b1;
      queue_cmd(CMD_CLEAR, ID_W'($urandom), any_pos());
      for (k = 0; k < TILE_ATOMS + 2; k++) begin
         queue_cmd(CMD_LOAD, ID_W'($urandom), any_pos());
      end
      for (k = 0; k < TILE_ATOMS + 1; k++) begin
         queue_cmd(CMD_PROBE, ID_W'($urandom), any_pos());
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
